### sv/ipdfr_pkg.sv
// Shared constants, types and helpers of the IPD command frame receiver.
// No dependencies; every other file but ipdfr_if takes its names from here by scope.
`timescale 1ns / 1ps
`default_nettype none
package ipdfr_pkg;

  localparam int PAYLOAD_MAX = 32;
  localparam int HEADER_MAX  = 32;

  localparam int IDX_W  = $clog2(PAYLOAD_MAX);
  localparam int MEM_AW = IDX_W + 1;
  localparam int HCNT_W = $clog2(HEADER_MAX);

  localparam logic [7:0] FRAME_HEAD = 8'hAA;
  localparam logic [7:0] FRAME_TAIL = 8'h55;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // header phases: 0..3 walk the "IPD," prefix
  localparam logic [2:0] PH_DIGITS1 = 3'd4;
  localparam logic [2:0] PH_DIGITS2 = 3'd5;
  localparam logic [2:0] PH_BAD     = 3'd6;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        data;
  } wr_port_t;

  typedef struct packed {
    logic [7:0] link;
    logic [7:0] cmd;
    logic [5:0] len;
    logic       bank;
  } frame_desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] prefix_char(input logic [1:0] ph);
    logic [7:0] ch;
    unique case (ph)
      2'd0:    ch = 8'h49;  // I
      2'd1:    ch = 8'h50;  // P
      2'd2:    ch = 8'h44;  // D
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

### sv/ipdfr_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
// Depends on nothing but the port widths of the receiver.
`timescale 1ns / 1ps
`default_nettype none
interface ipdfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ipdfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] link_id;
  logic [7:0] command;
  logic [5:0] payload_length;
  logic [4:0] byte_index;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output link_id, output command, output payload_length,
                  output byte_index, output payload_byte, output byte_valid,
                  output last, input ready);
  modport sink   (input valid, input link_id, input command, input payload_length,
                  input byte_index, input payload_byte, input byte_valid,
                  input last, output ready);
endinterface
`default_nettype wire

### sv/ipdfr_front.sv
// Byte parser: header check, frame capture, sum and tail check.
// Depends on ipdfr_pkg and ipdfr_in_if; feeds the payload RAM and descriptor queue.
`timescale 1ns / 1ps
`default_nettype none
module ipdfr_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  ipdfr_in_if.sink                    in_ch,
  input  wire ipdfr_pkg::q_status_t   q_stat,
  output ipdfr_pkg::wr_port_t         wr,
  output logic                        push,
  output ipdfr_pkg::frame_desc_t      desc
);

  localparam logic [1:0] M_IDLE   = 2'd0;
  localparam logic [1:0] M_HEADER = 2'd1;
  localparam logic [1:0] M_WAIT   = 2'd2;
  localparam logic [1:0] M_BODY   = 2'd3;

  localparam logic [ipdfr_pkg::HCNT_W:0] HDR_LIMIT =
    (ipdfr_pkg::HCNT_W + 1)'(ipdfr_pkg::HEADER_MAX - 1);

  logic [1:0]                   mode_r, mode_nxt;
  logic [ipdfr_pkg::HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [ipdfr_pkg::HCNT_W:0]   hcnt_inc;
  logic [2:0]                   phase_r, phase_nxt;
  logic [7:0]                   acc_r, acc_nxt;
  logic                         seen_r, seen_nxt;
  logic [7:0]                   link_r, link_nxt;
  logic [5:0]                   fcnt_r, fcnt_nxt;
  logic [5:0]                   pidx;
  logic [7:0]                   cmd_r, cmd_nxt;
  logic [5:0]                   flen_r, flen_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic                         bank_r, bank_nxt;
  logic                         fire;
  logic [7:0]                   b;
  logic                         is_digit;
  logic [7:0]                   digit;

  assign in_ch.ready = !q_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign is_digit    = (b >= ipdfr_pkg::CH_ZERO) && (b <= ipdfr_pkg::CH_NINE);
  assign digit       = b - ipdfr_pkg::CH_ZERO;
  assign hcnt_inc    = {1'b0, hcnt_r} + 1'b1;
  assign pidx        = fcnt_r - 6'd2;

  assign desc.link = link_r;
  assign desc.cmd  = cmd_r;
  assign desc.len  = flen_r;
  assign desc.bank = bank_r;

  always_comb begin
    mode_nxt  = mode_r;
    hcnt_nxt  = hcnt_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    link_nxt  = link_r;
    fcnt_nxt  = fcnt_r;
    cmd_nxt   = cmd_r;
    flen_nxt  = flen_r;
    sum_nxt   = sum_r;
    bank_nxt  = bank_r;
    push      = 1'b0;
    wr.we     = 1'b0;
    wr.addr   = {bank_r, pidx[ipdfr_pkg::IDX_W-1:0]};
    wr.data   = b;
    if (fire) begin
      unique case (mode_r)
        M_IDLE: begin
          if (b == ipdfr_pkg::CH_PLUS) begin
            mode_nxt  = M_HEADER;
            hcnt_nxt  = ipdfr_pkg::HCNT_W'(1);
            phase_nxt = 3'd0;
            acc_nxt   = 8'd0;
            seen_nxt  = 1'b0;
          end else if (b == ipdfr_pkg::FRAME_HEAD) begin
            mode_nxt = M_BODY;
            fcnt_nxt = 6'd0;
            flen_nxt = 6'd0;
            sum_nxt  = 8'd0;
          end
        end
        M_HEADER: begin
          hcnt_nxt = hcnt_inc[ipdfr_pkg::HCNT_W-1:0];
          // length limit wins over the colon test
          if (hcnt_inc >= HDR_LIMIT) begin
            mode_nxt = M_IDLE;
          end else if (b == ipdfr_pkg::CH_COLON) begin
            if (phase_r == ipdfr_pkg::PH_DIGITS2 && seen_r) begin
              link_nxt = acc_r;
              mode_nxt = M_WAIT;
            end else begin
              mode_nxt = M_IDLE;
            end
          end else if (phase_r < ipdfr_pkg::PH_DIGITS1) begin
            phase_nxt = (b == ipdfr_pkg::prefix_char(phase_r[1:0])) ?
                        phase_r + 3'd1 : ipdfr_pkg::PH_BAD;
          end else if (phase_r == ipdfr_pkg::PH_DIGITS1) begin
            if (is_digit) begin
              acc_nxt  = 8'((acc_r << 3) + (acc_r << 1) + digit);
              seen_nxt = 1'b1;
            end else if (b == ipdfr_pkg::CH_COMMA && seen_r) begin
              phase_nxt = ipdfr_pkg::PH_DIGITS2;
              seen_nxt  = 1'b0;
            end else begin
              phase_nxt = ipdfr_pkg::PH_BAD;
            end
          end else if (phase_r == ipdfr_pkg::PH_DIGITS2) begin
            if (is_digit) seen_nxt = 1'b1;
            else          phase_nxt = ipdfr_pkg::PH_BAD;
          end
        end
        M_WAIT: begin
          if (b == ipdfr_pkg::FRAME_HEAD) begin
            mode_nxt = M_BODY;
            fcnt_nxt = 6'd0;
            flen_nxt = 6'd0;
            sum_nxt  = 8'd0;
          end
        end
        M_BODY: begin
          if (fcnt_r == 6'd0) begin
            cmd_nxt  = b;
            sum_nxt  = b;
            fcnt_nxt = fcnt_r + 6'd1;
          end else if (fcnt_r == 6'd1) begin
            if (b > 8'(ipdfr_pkg::PAYLOAD_MAX)) begin
              mode_nxt = M_IDLE;
            end else begin
              flen_nxt = b[5:0];
              sum_nxt  = sum_r + b;
              fcnt_nxt = fcnt_r + 6'd1;
            end
          end else if (pidx < flen_r) begin
            wr.we    = 1'b1;
            sum_nxt  = sum_r + b;
            fcnt_nxt = fcnt_r + 6'd1;
          end else if (pidx == flen_r) begin
            sum_nxt  = sum_r ^ b;
            fcnt_nxt = fcnt_r + 6'd1;
          end else begin
            mode_nxt = M_IDLE;
            if (b == ipdfr_pkg::FRAME_TAIL && sum_r == 8'd0) begin
              push     = 1'b1;
              bank_nxt = !bank_r;
            end
          end
        end
        default: mode_nxt = M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      hcnt_r  <= '0;
      phase_r <= 3'd0;
      acc_r   <= 8'd0;
      seen_r  <= 1'b0;
      link_r  <= 8'd0;
      fcnt_r  <= 6'd0;
      cmd_r   <= 8'd0;
      flen_r  <= 6'd0;
      sum_r   <= 8'd0;
      bank_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      hcnt_r  <= hcnt_nxt;
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      link_r  <= link_nxt;
      fcnt_r  <= fcnt_nxt;
      cmd_r   <= cmd_nxt;
      flen_r  <= flen_nxt;
      sum_r   <= sum_nxt;
      bank_r  <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/ipdfr_queue.sv
// Two-entry queue of validated frame descriptors between parser and drain.
// Depends on ipdfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipdfr_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire ipdfr_pkg::frame_desc_t push_desc,
  input  wire logic                   pop,
  output ipdfr_pkg::frame_desc_t      head,
  output ipdfr_pkg::q_status_t        q_stat
);

  ipdfr_pkg::frame_desc_t entry_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign head         = entry_r[rptr_r];
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_stat.full  = (cnt_r == 2'd2);

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop  ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  as_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!q_stat.full || pop)) else $error("descriptor pushed into full queue");
  as_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("descriptor popped from empty queue");

endmodule
`default_nettype wire

### sv/ipdfr_back.sv
// Result drain: double-banked payload RAM and per-byte result sequencer.
// Depends on ipdfr_pkg and ipdfr_out_if; reads descriptors from ipdfr_queue.
`timescale 1ns / 1ps
`default_nettype none
module ipdfr_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire ipdfr_pkg::wr_port_t    wr,
  input  wire ipdfr_pkg::frame_desc_t head,
  input  wire ipdfr_pkg::q_status_t   q_stat,
  output logic                        pop,
  ipdfr_out_if.source                 out_ch
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_READ = 2'd1;
  localparam logic [1:0] B_LOAD = 2'd2;

  logic [7:0] mem [2**ipdfr_pkg::MEM_AW];
  logic [7:0] rd_data_r;
  logic       rd_en;

  logic [1:0]                  state_r, state_nxt;
  logic [ipdfr_pkg::IDX_W-1:0] k_r, k_nxt;
  logic                        last_hit;
  logic                        has_data;
  logic                        load;

  logic       ovalid_r, ovalid_nxt;
  logic [7:0] olink_r, ocmd_r, obyte_r;
  logic [5:0] olen_r;
  logic [4:0] oidx_r;
  logic       obv_r, olast_r;

  assign has_data = (head.len != 6'd0);
  assign last_hit = !has_data || ({1'b0, k_r} == head.len - 6'd1);
  assign rd_en    = (state_r == B_READ);
  assign load     = (state_r == B_LOAD) && (!ovalid_r || out_ch.ready);
  assign pop      = load && last_hit;

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[{head.bank, k_r}];
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          k_nxt     = '0;
          state_nxt = B_READ;
        end
      end
      B_READ: state_nxt = B_LOAD;
      B_LOAD: begin
        if (load) begin
          if (last_hit) begin
            state_nxt = B_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = B_READ;
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load)              ovalid_nxt = 1'b1;
    else if (out_ch.ready) ovalid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      olink_r <= head.link;
      ocmd_r  <= head.cmd;
      olen_r  <= head.len;
      oidx_r  <= 5'(k_r);
      obyte_r <= has_data ? rd_data_r : 8'd0;
      obv_r   <= has_data;
      olast_r <= last_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      k_r      <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.link_id        = olink_r;
  assign out_ch.command        = ocmd_r;
  assign out_ch.payload_length = olen_r;
  assign out_ch.byte_index     = oidx_r;
  assign out_ch.payload_byte   = obyte_r;
  assign out_ch.byte_valid     = obv_r;
  assign out_ch.last           = olast_r;

  as_drain_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !q_stat.empty) else $error("drain active without a frame");

endmodule
`default_nettype wire

### sv/ipd_command_frame_receiver.sv
// Top level of the IPD command frame receiver: parser, descriptor queue, drain.
// Depends on ipdfr_pkg, ipdfr_if, ipdfr_front, ipdfr_queue and ipdfr_back.
`timescale 1ns / 1ps
`default_nettype none
// The receiver takes one serial byte per beat on in_ch and accepts it while the
// queue is not full. A "+IPD,<link>,<len>:" header records the link number, then
// the parser waits for 0xAA; a bare 0xAA in idle opens a frame at once. A frame
// is 0xAA, command, length (up to 32), payload, sum and 0x55. Frames with a good
// sum and tail produce one result beat per payload byte on out_ch (one beat
// with byte_valid low for an empty payload), the final beat flagged by last.
// Each result beat passes the drain's RAM read, then its output register load,
// which waits while out_ch stalls. The payload RAM has two banks and the
// descriptor queue two entries: the parser keeps taking bytes while one frame
// drains and stalls in_ch only when the queue holds two validated frames.
module ipd_command_frame_receiver (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ipdfr_in_if.sink    in_ch,
  ipdfr_out_if.source out_ch
);

  ipdfr_pkg::wr_port_t    wr;
  ipdfr_pkg::frame_desc_t push_desc;
  ipdfr_pkg::frame_desc_t head;
  ipdfr_pkg::q_status_t   q_stat;
  logic                   push;
  logic                   pop;

  // classify bytes, capture payload into the free bank, push good frames
  ipdfr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .wr     (wr),
    .push   (push),
    .desc   (push_desc)
  );

  // hold validated frames until the drain takes them
  ipdfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // walk the head frame's bank and emit result beats
  ipdfr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // the parser must never write the bank the drain is reading
  as_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && !q_stat.empty) |-> (wr.addr[ipdfr_pkg::MEM_AW-1] != head.bank))
    else $error("payload write into bank being drained");
  as_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> (!wr.we && !push))
    else $error("parser active while both banks are held");

endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for the IPD command frame receiver: directed and random byte streams.
// Depends on ipdfr_pkg, ipdfr_if and ipd_command_frame_receiver; predicts results in-house.
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_BYTES = 110;
  localparam int MIN_RAND_BEATS = 48;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIR_ROWS   = 26;

  // One result beat, laid out in port order.
  typedef struct packed {
    logic [7:0] link_id;
    logic [7:0] command;
    logic [5:0] payload_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;
  } frame_beat_t;

  localparam frame_beat_t NO_BEAT = '0;

  typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_WAIT_HEAD, RX_BODY} rx_mode_t;
  typedef enum {PC_TEXT, PC_FILL, PC_FRAME, PC_BAD_SUM, PC_BAD_TAIL, PC_LONG} piece_t;
  typedef enum {FL_NONE, FL_SUM, FL_TAIL} frame_flaw_t;

  // Directed row: a piece of the byte stream. a/b are command/length for frames,
  // byte/count for fills. typed rows carry their single result beat spelled out.
  typedef struct {
    piece_t      kind;
    string       text;
    int          a;
    int          b;
    bit          typed;
    frame_beat_t want;
  } stim_row_t;

  stim_row_t dir_rows [N_DIR_ROWS] = '{
    // bare head right after reset: link 0, empty payload, command extremes
    '{PC_FRAME, "", 'h00, 0, 1'b1, '{8'h00, 8'h00, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}},
    '{PC_FRAME, "", 'hFF, 0, 1'b1, '{8'h00, 8'hFF, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}},
    '{PC_TEXT, "+IPD,0,0:", 0, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'h12, 1, 1'b0, NO_BEAT},
    // largest plain link; a '+' and stray text while waiting for the head
    '{PC_TEXT, "+IPD,255,9999:", 0, 0, 1'b0, NO_BEAT},
    '{PC_TEXT, "+x", 0, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'h80, 0, 1'b1, '{8'hFF, 8'h80, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}},
    // link wraps modulo 256 (1000 -> 232), then a full-size payload
    '{PC_TEXT, "+IPD,1000,5:", 0, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'h7F, 32, 1'b0, NO_BEAT},
    // malformed headers: none of them may touch the held link
    '{PC_TEXT, "+IPD, 3,4:", 0, 0, 1'b0, NO_BEAT},
    '{PC_TEXT, "+ipd,3,4:", 0, 0, 1'b0, NO_BEAT},
    '{PC_TEXT, "+IPD,,4:", 0, 0, 1'b0, NO_BEAT},
    '{PC_TEXT, "+IPD,3,:", 0, 0, 1'b0, NO_BEAT},
    '{PC_TEXT, "+IPD,3,4,5:", 0, 0, 1'b0, NO_BEAT},
    // a head byte inside a broken header is swallowed until the colon
    '{PC_TEXT, "+IPD,3", 0, 0, 1'b0, NO_BEAT},
    '{PC_FILL, "", 'hAA, 1, 1'b0, NO_BEAT},
    '{PC_TEXT, "4:", 0, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'h01, 0, 1'b1, '{8'hE8, 8'h01, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1}},
    // header length limit: 30 bytes still pass, 31 bytes do not
    '{PC_TEXT, "+IPD,5,0000000000000000000000:", 0, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'h5A, 2, 1'b0, NO_BEAT},
    '{PC_TEXT, "+IPD,6,00000000000000000000000:", 0, 0, 1'b0, NO_BEAT},
    // aborted and dropped frames
    '{PC_LONG, "", 'h33, 33, 1'b0, NO_BEAT},
    '{PC_LONG, "", 'h44, 255, 1'b0, NO_BEAT},
    '{PC_BAD_SUM, "", 'h10, 3, 1'b0, NO_BEAT},
    '{PC_BAD_TAIL, "", 'h20, 0, 1'b0, NO_BEAT},
    '{PC_FRAME, "", 'hC3, 0, 1'b0, NO_BEAT}
  };

  logic clk = 1'b0;
  logic rst_n;

  ipdfr_in_if  in_ch ();
  ipdfr_out_if out_ch ();

  ipd_command_frame_receiver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser, advanced once per byte beat.
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode    = RX_IDLE;
  int unsigned hdr_count  = 0;
  logic [2:0]  hdr_phase  = '0;
  logic [7:0]  link_acc   = '0;
  bit          digit_seen = 1'b0;
  logic [7:0]  held_link  = '0;
  int unsigned body_pos   = 0;
  logic [7:0]  frm_cmd    = '0;
  logic [5:0]  frm_len    = '0;
  logic [7:0]  frm_sum    = '0;
  logic [7:0]  frm_payload [ipdfr_pkg::PAYLOAD_MAX];

  frame_beat_t pending_beats [$];

  int mismatch_count  = 0;
  int cycle_count     = 0;
  int bytes_sent      = 0;
  int noise_bytes     = 0;
  int beats_predicted = 0;
  int frames_predicted = 0;
  int beats_checked   = 0;
  int header_frames   = 0;
  int holds_asked     = 0;
  int holds_done      = 0;
  int calm_left       = 0;
  bit burst           = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Advance the predicted parser by one byte; append any result beats it emits.
  task automatic frame_predict(input logic [7:0] c, ref frame_beat_t beats[$]);
    logic [7:0]  want_ch;
    int unsigned nbeats;
    frame_beat_t beat;
    if (rx_mode == RX_IDLE && c == ipdfr_pkg::CH_PLUS) begin
      rx_mode    = RX_HEADER;
      hdr_count  = 1;
      hdr_phase  = '0;
      link_acc   = '0;
      digit_seen = 1'b0;
    end else if ((rx_mode == RX_IDLE || rx_mode == RX_WAIT_HEAD) &&
                 c == ipdfr_pkg::FRAME_HEAD) begin
      rx_mode  = RX_BODY;
      body_pos = 0;
      frm_len  = '0;
      frm_sum  = '0;
    end else if (rx_mode == RX_HEADER) begin
      hdr_count++;
      // the length limit wins over the colon
      if (hdr_count >= ipdfr_pkg::HEADER_MAX - 1) begin
        rx_mode = RX_IDLE;
      end else if (c == ipdfr_pkg::CH_COLON) begin
        if (hdr_phase == ipdfr_pkg::PH_DIGITS2 && digit_seen) begin
          held_link = link_acc;
          rx_mode   = RX_WAIT_HEAD;
        end else begin
          rx_mode = RX_IDLE;
        end
      end else if (hdr_phase < ipdfr_pkg::PH_DIGITS1) begin
        case (hdr_phase[1:0])
          2'd0:    want_ch = "I";
          2'd1:    want_ch = "P";
          2'd2:    want_ch = "D";
          default: want_ch = ",";
        endcase
        hdr_phase = (c == want_ch) ? hdr_phase + 3'd1 : ipdfr_pkg::PH_BAD;
      end else if (hdr_phase == ipdfr_pkg::PH_DIGITS1) begin
        if (c >= ipdfr_pkg::CH_ZERO && c <= ipdfr_pkg::CH_NINE) begin
          link_acc   = link_acc * 8'd10 + (c - ipdfr_pkg::CH_ZERO);
          digit_seen = 1'b1;
        end else if (c == ipdfr_pkg::CH_COMMA && digit_seen) begin
          hdr_phase  = ipdfr_pkg::PH_DIGITS2;
          digit_seen = 1'b0;
        end else begin
          hdr_phase = ipdfr_pkg::PH_BAD;
        end
      end else if (hdr_phase == ipdfr_pkg::PH_DIGITS2) begin
        if (c >= ipdfr_pkg::CH_ZERO && c <= ipdfr_pkg::CH_NINE) begin
          digit_seen = 1'b1;
        end else begin
          hdr_phase = ipdfr_pkg::PH_BAD;
        end
      end
    end else if (rx_mode == RX_BODY) begin
      if (body_pos == 0) begin
        frm_cmd = c;
        frm_sum = c;
        body_pos++;
      end else if (body_pos == 1) begin
        if (c > ipdfr_pkg::PAYLOAD_MAX) begin
          rx_mode = RX_IDLE;
        end else begin
          frm_len = c[5:0];
          frm_sum = frm_sum + c;
          body_pos++;
        end
      end else if (body_pos - 2 < frm_len) begin
        frm_payload[body_pos - 2] = c;
        frm_sum = frm_sum + c;
        body_pos++;
      end else if (body_pos - 2 == frm_len) begin
        frm_sum = frm_sum ^ c;
        body_pos++;
      end else begin
        rx_mode = RX_IDLE;
        if (c == ipdfr_pkg::FRAME_TAIL && frm_sum == 8'h00) begin
          nbeats = (frm_len == 0) ? 1 : frm_len;
          for (int k = 0; k < nbeats; k++) begin
            beat.link_id        = held_link;
            beat.command        = frm_cmd;
            beat.payload_length = frm_len;
            beat.byte_index     = k[4:0];
            beat.payload_byte   = (frm_len != 0) ? frm_payload[k] : 8'h00;
            beat.byte_valid     = (frm_len != 0);
            beat.last           = (k == nbeats - 1);
            beats.push_back(beat);
          end
        end
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 90) return $urandom_range(7, 31);
    return ipdfr_pkg::PAYLOAD_MAX;
  endfunction

  // Offer one byte beat, hold it until accepted, then predict and idle for a random gap, if any.
  // Called at a rising edge; returns at a rising edge, with valid still driven only if there was no gap.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input frame_beat_t want = '0);
    frame_beat_t fresh [$];
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
    frame_predict(b, fresh);
    if (fresh.size() != 0) frames_predicted++;
    if (typed) begin
      pending_beats.push_back(want);
      beats_predicted++;
    end else begin
      foreach (fresh[i]) pending_beats.push_back(fresh[i]);
      beats_predicted += fresh.size();
    end
    if (burst || calm_left > 0) begin
      gap = 0;
      if (calm_left > 0) calm_left--;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Head, command, length, payload, sum, tail; a flaw spoils the sum or the tail.
  task automatic send_frame(input logic [7:0] cmd, input int len, input frame_flaw_t flaw,
                            input bit typed = 1'b0, input frame_beat_t want = '0);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] tail;
    sum = cmd + 8'(len);
    send_byte(ipdfr_pkg::FRAME_HEAD);
    send_byte(cmd);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      pb  = 8'($urandom);
      sum = sum + pb;
      send_byte(pb);
    end
    if (flaw == FL_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    tail = ipdfr_pkg::FRAME_TAIL;
    if (flaw == FL_TAIL) begin
      while (tail == ipdfr_pkg::FRAME_TAIL) tail = 8'($urandom);
    end
    send_byte(tail, typed, want);
  endtask

  task automatic run_piece(input stim_row_t row);
    case (row.kind)
      PC_TEXT:     send_text(row.text);
      PC_FILL:     repeat (row.b) send_byte(8'(row.a));
      PC_FRAME:    send_frame(8'(row.a), row.b, FL_NONE, row.typed, row.want);
      PC_BAD_SUM:  send_frame(8'(row.a), row.b, FL_SUM);
      PC_BAD_TAIL: send_frame(8'(row.a), row.b, FL_TAIL);
      default: begin
        send_byte(ipdfr_pkg::FRAME_HEAD);
        send_byte(8'(row.a));
        send_byte(8'(row.b));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check every accepted beat against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_beat_t got;
    frame_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.link_id, out_ch.command, out_ch.payload_length, out_ch.byte_index,
              out_ch.payload_byte, out_ch.byte_valid, out_ch.last};
      if (pending_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", got));
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (got.link_id !== want.link_id)
          report_mismatch($sformatf("link_id %h, want %h", got.link_id, want.link_id));
        if (got.command !== want.command)
          report_mismatch($sformatf("command %h, want %h", got.command, want.command));
        if (got.payload_length !== want.payload_length)
          report_mismatch($sformatf("payload_length %0d, want %0d",
                                    got.payload_length, want.payload_length));
        if (got.byte_index !== want.byte_index)
          report_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index,
                                    want.byte_index));
        if (got.payload_byte !== want.payload_byte)
          report_mismatch($sformatf("payload_byte %h, want %h", got.payload_byte,
                                    want.payload_byte));
        if (got.byte_valid !== want.byte_valid)
          report_mismatch($sformatf("byte_valid %b, want %b", got.byte_valid,
                                    want.byte_valid));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
    end
  end

  // Receiver back-pressure: random stalls, calm stretches, and a long hold-off
  // whenever the stimulus asks for one.
  initial begin
    int stall_left;
    int run_left;
    int hold_left;
    stall_left   = 0;
    run_left     = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          run_left--;
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d beats still pending", cycle_count,
               pending_beats.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed rows, then random streams, then drain and verdict.
  // ---------------------------------------------------------------------------
  initial begin
    int          rand_start;
    int          beat_start;
    int          pick;
    int          nz;
    int          pos;
    string       hdr;
    logic [7:0]  junk;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    rst_n         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) run_piece(dir_rows[i]);

    // Random part: mostly well-formed frames with random content; the rest are
    // broken headers, spoiled frames and line noise. Noise does not count.
    rand_start = bytes_sent;
    beat_start = beats_predicted;
    while (bytes_sent - noise_bytes - rand_start < RANDOM_BYTES ||
           beats_predicted - beat_start < MIN_RAND_BEATS || holds_asked == 0) begin
      // once, back-to-back frames against a stalled receiver so the block fills
      if (holds_asked == 0 && frames_predicted >= 10) begin
        holds_asked++;
        burst = 1'b1;
        repeat (5) send_frame(8'($urandom), $urandom_range(4, 10), FL_NONE);
        burst = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if ($urandom_range(0, 1) == 1) begin
          send_text($sformatf("+IPD,%0d,%0d:", $urandom_range(0, 9999),
                              $urandom_range(0, 99999)));
          header_frames++;
          // junk while waiting for the head must be ignored
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              junk = 8'($urandom);
              if (junk == ipdfr_pkg::FRAME_HEAD) junk = ipdfr_pkg::CH_PLUS;
              send_byte(junk);
            end
          end
        end
        send_frame(8'($urandom), pick_len(), FL_NONE);
      end else if (pick < 60) begin
        send_frame(8'($urandom), pick_len(), FL_SUM);
      end else if (pick < 70) begin
        send_frame(8'($urandom), pick_len(), FL_TAIL);
      end else if (pick < 76) begin
        send_byte(ipdfr_pkg::FRAME_HEAD);
        send_byte(8'($urandom));
        send_byte(8'($urandom_range(ipdfr_pkg::PAYLOAD_MAX + 1, 255)));
      end else if (pick < 88) begin
        if ($urandom_range(0, 3) == 0) begin
          // padded second number around the header length limit
          nz = $urandom_range(20, 26);
          send_text("+IPD,7,");
          repeat (nz) send_byte(ipdfr_pkg::CH_ZERO);
          send_byte(ipdfr_pkg::CH_COLON);
        end else begin
          // corrupt one byte of an otherwise good header
          hdr = $sformatf("+IPD,%0d,%0d:", $urandom_range(0, 999), $urandom_range(0, 999));
          pos = $urandom_range(1, hdr.len() - 1);
          for (int i = 0; i < hdr.len(); i++) begin
            send_byte((i == pos) ? 8'($urandom) : hdr[i]);
          end
        end
        send_frame(8'($urandom), pick_len(), FL_NONE);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom));
          noise_bytes++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Wait out the drain, then linger so stray beats would still be caught.
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes (%0d noise); %0d frames expected, %0d of %0d beats checked",
             bytes_sent, noise_bytes, frames_predicted, beats_checked, beats_predicted);
    $display("Header-led frames: %0d; long receiver hold-offs: %0d",
             header_frames, holds_done);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
